>>> design/ogcc_pkg.sv
// Package for the occupancy grid collision check block.
// Holds shared widths, register indexes, outcome codes and divider port types.
// No dependencies.
`timescale 1ns / 1ps

package ogcc_pkg;

    // Default geometry and search settings.
    localparam int MAX_COLS_DEF      = 128;
    localparam int MAX_ROWS_DEF      = 128;
    localparam int SEARCH_RADIUS_DEF = 2;

    // Field widths of the stream payloads and the register port.
    localparam int PT_W      = 21;
    localparam int ID_W      = 15;
    localparam int IN_DATA_W = 64;
    localparam int OUT_W     = 2;
    localparam int OUT_DATA_W = 8;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Integer pixel part of a coordinate and the cell size, as seen by the divider.
    localparam int DVD_W = 12;
    localparam int DVS_W = 8;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CELL_SIZE    = 3'd0;
    localparam logic [2:0] REG_GRID_COLS    = 3'd1;
    localparam logic [2:0] REG_GRID_ROWS    = 3'd2;
    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FIELD_HEIGHT = 3'd4;

    // Reset values of the registers.
    localparam logic [7:0]  CELL_SIZE_RST    = 8'd10;
    localparam logic [7:0]  GRID_COLS_RST    = 8'd128;
    localparam logic [7:0]  GRID_ROWS_RST    = 8'd128;
    localparam logic [11:0] FIELD_WIDTH_RST  = 12'd1024;
    localparam logic [11:0] FIELD_HEIGHT_RST = 12'd1024;

    // Outcome codes.
    localparam logic [OUT_W-1:0] OUTC_FREE   = 2'd0;
    localparam logic [OUT_W-1:0] OUTC_BORDER = 2'd1;
    localparam logic [OUT_W-1:0] OUTC_NEAR   = 2'd2;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    // Response of the shared divider.
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> design/ogcc_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Shared by the x and y cell computations; depends on ogcc_pkg.
`timescale 1ns / 1ps

module ogcc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ogcc_pkg::t_div_req i_req,
    output ogcc_pkg::t_div_rsp o_rsp
);
    import ogcc_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_dvs;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] n_rem;

    // One trial subtraction per cycle.
    always_comb begin
        trial = {r_rem, r_q[DVD_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
        n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    // Iteration control and the quotient shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[DVD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

>>> design/occupancy_grid_collision_check.sv
// Top level of the occupancy grid collision check: register port, sequencer, owner store.
// Depends on ogcc_pkg and ogcc_div.
//
// After reset the block sweeps the owner store to empty, one entry per cycle, over all
// MAX_COLS*MAX_ROWS entries (16384 with the defaults); no request is taken meanwhile,
// register writes are. A request whose point lies on or beyond the field border skips
// the divider and goes straight to the hand-over. Any other request has its x cell, then
// its y cell computed in the shared bit-serial divider; the (2*SEARCH_RADIUS+1)^2
// neighborhood cells are then scanned through the single read port of the owner store,
// the point's own cell is written if it lies in the grid, and the result is handed over.
// A collision ends the scan early and skips the write. One request is in work at a time;
// a finished result waits in the output register while the next request is taken, and
// the hand-over stalls while that register is still full. Registers should be written
// only while the block is idle.
`timescale 1ns / 1ps

module occupancy_grid_collision_check #(
    parameter int MAX_COLS      = ogcc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS      = ogcc_pkg::MAX_ROWS_DEF,
    parameter int SEARCH_RADIUS = ogcc_pkg::SEARCH_RADIUS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogcc_pkg::APB_AW-1:0]       paddr,
    input  logic [ogcc_pkg::APB_DW-1:0]       pwdata,
    output logic [ogcc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point_x [20:0], point_y [41:21], line_id [56:42], zero [63:57]
    input  logic [ogcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // outcome [1:0], zero [7:2]
    output logic [ogcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import ogcc_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int N     = 2 * SEARCH_RADIUS + 1;
    localparam int OW    = $clog2(N);
    localparam int SUMW  = (AW > 17) ? AW : 17;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [7:0]  r_cell_size;
    logic [7:0]  r_grid_cols;
    logic [7:0]  r_grid_rows;
    logic [11:0] r_field_width;
    logic [11:0] r_field_height;

    // Request and sequencer registers.
    logic [AW-1:0]       r_clr;
    logic [DVD_W-1:0]    r_y_int;
    logic [ID_W-1:0]     r_id;
    logic [DVD_W-1:0]    r_cx;
    logic [DVD_W-1:0]    r_cy;
    logic [OW-1:0]       r_dx;
    logic [OW-1:0]       r_dy;
    logic                r_issuing;
    logic                r_s1_vld;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s2_vld;
    logic [15:0]         r_rd;
    logic                r_own_in;
    logic [AW-1:0]       r_own_addr;
    logic [OUT_W-1:0]    r_outcome;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;

    // Owner store: bit 15 marks an occupied cell, bits 14..0 hold the owning line.
    logic [15:0] mem [DEPTH];

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [PT_W-1:0]    s_x;
    logic [PT_W-1:0]    s_y;
    logic [ID_W-1:0]    s_id;
    logic               border;
    logic               take;
    logic [7:0]         cs_eff;
    logic [7:0]         cols;
    logic [7:0]         rows;
    logic signed [13:0] nx;
    logic signed [13:0] ny;
    logic               in_grid;
    logic [15:0]        prod;
    logic [SUMW-1:0]    sum;
    logic [AW-1:0]      addr;
    logic               last_issue;
    logic               center;
    logic               hit;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [15:0]        wdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // Register port decode.
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_CELL_SIZE:    prdata = APB_DW'(r_cell_size);
            REG_GRID_COLS:    prdata = APB_DW'(r_grid_cols);
            REG_GRID_ROWS:    prdata = APB_DW'(r_grid_rows);
            REG_FIELD_WIDTH:  prdata = APB_DW'(r_field_width);
            REG_FIELD_HEIGHT: prdata = APB_DW'(r_field_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size    <= CELL_SIZE_RST;
            r_grid_cols    <= GRID_COLS_RST;
            r_grid_rows    <= GRID_ROWS_RST;
            r_field_width  <= FIELD_WIDTH_RST;
            r_field_height <= FIELD_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CELL_SIZE:    r_cell_size    <= pwdata[7:0];
                REG_GRID_COLS:    r_grid_cols    <= pwdata[7:0];
                REG_GRID_ROWS:    r_grid_rows    <= pwdata[7:0];
                REG_FIELD_WIDTH:  r_field_width  <= pwdata[11:0];
                REG_FIELD_HEIGHT: r_field_height <= pwdata[11:0];
                default:          ;
            endcase
        end
    end

    // Effective geometry: zero cell size acts as one, grid counts are clamped.
    always_comb begin
        cs_eff = (r_cell_size == 8'd0) ? 8'd1 : r_cell_size;
        cols   = (32'(r_grid_cols) > MAX_COLS) ? 8'(MAX_COLS) : r_grid_cols;
        rows   = (32'(r_grid_rows) > MAX_ROWS) ? 8'(MAX_ROWS) : r_grid_rows;
    end

    // Request fields and the border test in exact fixed point.
    always_comb begin
        s_x    = s_axis_tdata[PT_W-1:0];
        s_y    = s_axis_tdata[2*PT_W-1:PT_W];
        s_id   = s_axis_tdata[2*PT_W+ID_W-1:2*PT_W];
        border = s_x[PT_W-1] || (s_x == '0) ||
                 s_y[PT_W-1] || (s_y == '0) ||
                 (s_x[PT_W-2:0] >= {r_field_width, 8'd0}) ||
                 (s_y[PT_W-2:0] >= {r_field_height, 8'd0});
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;

    // Shared divider: x cell on acceptance, y cell when x is done.
    always_comb begin
        div_req.start    = (take && !border) || ((r_state == ST_DIVX) && div_rsp.done);
        div_req.dividend = (r_state == ST_IDLE) ? s_x[PT_W-2:8] : r_y_int;
        div_req.divisor  = cs_eff;
    end

    ogcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Neighbor address generation for the scan position in r_dx, r_dy.
    always_comb begin
        nx = $signed({2'b00, r_cx}) + $signed(14'(r_dx)) - 14'(SEARCH_RADIUS);
        ny = $signed({2'b00, r_cy}) + $signed(14'(r_dy)) - 14'(SEARCH_RADIUS);
        in_grid = !nx[13] && (nx[12:0] < 13'(cols)) &&
                  !ny[13] && (ny[12:0] < 13'(rows));
        prod = ny[7:0] * cols;
        sum  = SUMW'(prod) + SUMW'(nx[7:0]);
        addr = sum[AW-1:0];
        last_issue = (r_dx == OW'(N - 1)) && (r_dy == OW'(N - 1));
        center     = (r_dx == OW'(SEARCH_RADIUS)) && (r_dy == OW'(SEARCH_RADIUS));
        hit        = r_s2_vld && r_rd[15] && (r_rd[14:0] != r_id);
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_issuing <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // The hand-over in ST_DONE decides the output valid by itself.
            if (r_out_vld && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (take) begin
                        r_y_int <= s_y[PT_W-2:8];
                        r_id    <= s_id;
                        if (border) begin
                            r_outcome <= OUTC_BORDER;
                            r_state   <= ST_DONE;
                        end else begin
                            r_state <= ST_DIVX;
                        end
                    end
                end
                ST_DIVX: begin
                    if (div_rsp.done) begin
                        r_cx    <= div_rsp.quotient;
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (div_rsp.done) begin
                        r_cy      <= div_rsp.quotient;
                        r_dx      <= '0;
                        r_dy      <= '0;
                        r_issuing <= 1'b1;
                        r_s1_vld  <= 1'b0;
                        r_s2_vld  <= 1'b0;
                        r_own_in  <= 1'b0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        // Another line owns a nearby cell: stop and flush the reads.
                        r_outcome <= OUTC_NEAR;
                        r_issuing <= 1'b0;
                        r_s1_vld  <= 1'b0;
                        r_s2_vld  <= 1'b0;
                        r_state   <= ST_DONE;
                    end else begin
                        r_s1_vld  <= r_issuing && in_grid;
                        r_s1_addr <= addr;
                        r_s2_vld  <= r_s1_vld;
                        if (r_issuing) begin
                            if (center) begin
                                r_own_in   <= in_grid;
                                r_own_addr <= addr;
                            end
                            if (r_dy == OW'(N - 1)) begin
                                r_dy <= '0;
                                r_dx <= r_dx + 1'b1;
                            end else begin
                                r_dy <= r_dy + 1'b1;
                            end
                            if (last_issue) begin
                                r_issuing <= 1'b0;
                            end
                        end
                        if (!r_issuing && !r_s1_vld && !r_s2_vld) begin
                            r_state <= ST_WRITE;
                        end
                    end
                end
                ST_WRITE: begin
                    r_outcome <= OUTC_FREE;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= r_outcome;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Store write: clearing sweep after reset, or marking the point's own cell.
    always_comb begin
        we    = (r_state == ST_CLEAR) || ((r_state == ST_WRITE) && r_own_in);
        waddr = (r_state == ST_CLEAR) ? r_clr : r_own_addr;
        wdata = (r_state == ST_CLEAR) ? 16'd0 : {1'b1, r_id};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port for the scan.
    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_s1_addr];
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

endmodule
